// ----- rtl/dtcr_pkg.sv -----
`default_nettype none

package dtcr_pkg;

    localparam int DepthW = 16;
    localparam int ThreshW = 16;
    localparam int ColorW = 8;
    localparam int CfgIndexW = 2;

    // Quotient bits resolved per divider stage; the quotient is DepthW bits wide.
    localparam int DivStageBits = 2;
    localparam int DivStages = DepthW / DivStageBits;

    localparam logic [CfgIndexW-1:0] CfgMinThreshold = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgMaxThreshold = 2'd1;

    localparam logic [ThreshW-1:0] MinThresholdReset = 16'd855;
    localparam logic [ThreshW-1:0] MaxThresholdReset = 16'd1000;

    typedef struct packed {
        logic [DepthW-1:0] rem;
        logic [DepthW-1:0] dsr;
        logic [DepthW-1:0] quo;
        logic              zero;
        logic              sat;
    } div_item_t;

endpackage

`default_nettype wire

// ----- rtl/dtcr_if.sv -----
`default_nettype none

interface dtcr_sample_if;
    logic                          valid;
    logic                          ready;
    logic [dtcr_pkg::DepthW-1:0]   depth;

    modport source (output valid, output depth, input ready);
    modport sink (input valid, input depth, output ready);
endinterface

interface dtcr_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [dtcr_pkg::ColorW-1:0]   red;
    logic [dtcr_pkg::ColorW-1:0]   green;
    logic [dtcr_pkg::ColorW-1:0]   blue;
    logic [dtcr_pkg::ColorW-1:0]   level;

    modport source (output valid, output red, output green, output blue, output level,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input level,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/dtcr_div_stage.sv -----
`default_nettype none

module dtcr_div_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dtcr_pkg::div_item_t   in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dtcr_pkg::div_item_t        out_item
);

    logic                 valid_reg;
    dtcr_pkg::div_item_t  item_reg;
    dtcr_pkg::div_item_t  item_next;
    logic                 en;

    // Restoring division: the remainder stays below the divisor, so each step
    // doubles it, subtracts the divisor when it fits and shifts in one quotient bit.
    always_comb
    begin
        logic [dtcr_pkg::DepthW:0] dbl;
        item_next = in_item;
        for (int i = 0; i < dtcr_pkg::DivStageBits; i++)
        begin
            dbl = {item_next.rem, 1'b0};
            if (dbl >= {1'b0, item_next.dsr})
            begin
                item_next.rem = dtcr_pkg::DepthW'(dbl - {1'b0, item_next.dsr});
                item_next.quo = {item_next.quo[dtcr_pkg::DepthW-2:0], 1'b1};
            end
            else
            begin
                item_next.rem = dbl[dtcr_pkg::DepthW-1:0];
                item_next.quo = {item_next.quo[dtcr_pkg::DepthW-2:0], 1'b0};
            end
        end
    end

    assign en = !valid_reg || out_ready;
    assign in_ready = en;
    assign out_valid = valid_reg;
    assign out_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/depth_to_color_ramp.sv -----
// Maps each raw depth sample to an RGB ramp color and a grey level. The sample
// is normalized against the two thresholds into a 17-bit fraction (clamped to
// 0..1.0), then colored. One sample is taken per clock when the output is not
// stalled, and each result passes through one setup stage, eight stages of a
// restoring divider that resolve two quotient bits each, one stage of constant
// products and the output register. A stall on the output backs up stage by
// stage, so empty stages still fill. Thresholds are written through
// cfg_we/cfg_index/cfg_wdata and should change only while no sample is in
// flight.
`default_nettype none

module depth_to_color_ramp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dtcr_pkg::CfgIndexW-1:0]     cfg_index,
    input  wire logic [dtcr_pkg::ThreshW-1:0]       cfg_wdata,
    dtcr_sample_if.sink                             sample,
    dtcr_pixel_if.source                            pixel
);

    localparam int DW = dtcr_pkg::DepthW;
    localparam int NS = dtcr_pkg::DivStages;

    logic [dtcr_pkg::ThreshW-1:0] min_threshold_reg;
    logic [dtcr_pkg::ThreshW-1:0] max_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_threshold_reg <= dtcr_pkg::MinThresholdReset;
            max_threshold_reg <= dtcr_pkg::MaxThresholdReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtcr_pkg::CfgMinThreshold)
            begin
                min_threshold_reg <= cfg_wdata;
            end
            if (cfg_index == dtcr_pkg::CfgMaxThreshold)
            begin
                max_threshold_reg <= cfg_wdata;
            end
        end
    end

    // Divider chain; index 0 is the setup stage.
    logic                 div_valid [0:NS];
    logic                 div_ready [0:NS];
    dtcr_pkg::div_item_t  div_item [0:NS];

    // Setup stage: decide the clamped cases and reduce the rest to an unsigned
    // division whose dividend is below its divisor.
    logic                 s0_valid_reg;
    dtcr_pkg::div_item_t  s0_item_reg;
    dtcr_pkg::div_item_t  s0_item_next;
    logic                 s0_en;

    always_comb
    begin
        s0_item_next.rem = '0;
        s0_item_next.dsr = '1;
        s0_item_next.quo = '0;
        s0_item_next.zero = 1'b0;
        s0_item_next.sat = 1'b0;
        if (min_threshold_reg == max_threshold_reg)
        begin
            s0_item_next.zero = 1'b1;
        end
        else if (max_threshold_reg > min_threshold_reg)
        begin
            if (sample.depth <= min_threshold_reg)
            begin
                s0_item_next.zero = 1'b1;
            end
            else if (sample.depth >= max_threshold_reg)
            begin
                s0_item_next.sat = 1'b1;
            end
            else
            begin
                s0_item_next.rem = sample.depth - min_threshold_reg;
                s0_item_next.dsr = max_threshold_reg - min_threshold_reg;
            end
        end
        else
        begin
            // Inverted thresholds: the ramp runs from min down to max.
            if (sample.depth >= min_threshold_reg)
            begin
                s0_item_next.zero = 1'b1;
            end
            else if (sample.depth <= max_threshold_reg)
            begin
                s0_item_next.sat = 1'b1;
            end
            else
            begin
                s0_item_next.rem = min_threshold_reg - sample.depth;
                s0_item_next.dsr = min_threshold_reg - max_threshold_reg;
            end
        end
    end

    assign s0_en = !s0_valid_reg || div_ready[0];
    assign sample.ready = s0_en;
    assign div_valid[0] = s0_valid_reg;
    assign div_item[0] = s0_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_en)
        begin
            s0_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en && sample.valid)
        begin
            s0_item_reg <= s0_item_next;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        dtcr_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_item   (div_item[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_item  (div_item[k+1])
        );
    end

    // Product stage: constant multiplies of the fraction for each channel.
    logic               p_valid_reg;
    logic [23:0]        p_red_reg;
    logic [24:0]        p_green_reg;
    logic [23:0]        p_blue_reg;
    logic [23:0]        p_level_reg;
    logic [23:0]        p_red_next;
    logic [24:0]        p_green_next;
    logic [23:0]        p_blue_next;
    logic [23:0]        p_level_next;
    logic               p_en;
    logic               out_en;

    always_comb
    begin
        logic [DW:0]   frac;
        logic [DW+1:0] two_a;
        logic [DW:0]   lo_span;
        logic [DW:0]   t;
        logic [DW:0]   hi_span;
        if (div_item[NS].zero)
        begin
            frac = '0;
        end
        else if (div_item[NS].sat)
        begin
            frac = {1'b1, {DW{1'b0}}};
        end
        else
        begin
            frac = {1'b0, div_item[NS].quo};
        end
        two_a = {frac, 1'b0};
        lo_span = (DW+1)'(18'd65536 - two_a);
        t = (DW+1)'(two_a - 18'd65536);
        hi_span = 17'd65536 - t;
        p_level_next = 24'd255 * 24'(frac);
        if (!frac[DW] && !frac[DW-1])
        begin
            p_red_next = 24'd255 * 24'(lo_span);
            p_green_next = 25'd33423360;
            p_blue_next = '0;
        end
        else
        begin
            p_red_next = 24'd51 * 24'(hi_span);
            p_green_next = 25'd33423360 - 25'd459 * 25'(t);
            p_blue_next = 24'd255 * 24'(t);
        end
    end

    assign p_en = !p_valid_reg || out_en;
    assign div_ready[NS] = p_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_en)
        begin
            p_valid_reg <= div_valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_en && div_valid[NS])
        begin
            p_red_reg <= p_red_next;
            p_green_reg <= p_green_next;
            p_blue_reg <= p_blue_next;
            p_level_reg <= p_level_next;
        end
    end

    // Output register: the floors are the upper bits of the products.
    logic                           o_valid_reg;
    logic [dtcr_pkg::ColorW-1:0]    o_red_reg;
    logic [dtcr_pkg::ColorW-1:0]    o_green_reg;
    logic [dtcr_pkg::ColorW-1:0]    o_blue_reg;
    logic [dtcr_pkg::ColorW-1:0]    o_level_reg;

    assign out_en = !o_valid_reg || pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && p_valid_reg)
        begin
            o_red_reg <= p_red_reg[23:16];
            o_green_reg <= p_green_reg[24:17];
            o_blue_reg <= p_blue_reg[23:16];
            o_level_reg <= p_level_reg[23:16];
        end
    end

    assign pixel.valid = o_valid_reg;
    assign pixel.red = o_red_reg;
    assign pixel.green = o_green_reg;
    assign pixel.blue = o_blue_reg;
    assign pixel.level = o_level_reg;

endmodule

`default_nettype wire

// ----- tb/tb_depth_to_color_ramp.sv -----
`default_nettype none

module tb_depth_to_color_ramp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 20;
    localparam int HoldOffCycles = 60;

    localparam longint QOne = 65536;
    localparam longint QHalf = 32768;

    // Indexes that decode to no register.
    localparam logic [dtcr_pkg::CfgIndexW-1:0] CfgUnusedLow = 2'd2;
    localparam logic [dtcr_pkg::CfgIndexW-1:0] CfgUnusedHigh = 2'd3;

    typedef enum int {
        RampAny,
        RampNarrow,
        RampInverted,
        RampFlat,
        RampWide,
        RampTiny
    } ramp_kind_t;

    typedef struct packed {
        logic [dtcr_pkg::ColorW-1:0] red;
        logic [dtcr_pkg::ColorW-1:0] green;
        logic [dtcr_pkg::ColorW-1:0] blue;
        logic [dtcr_pkg::ColorW-1:0] level;
    } pixel_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dtcr_pkg::CfgIndexW-1:0] cfg_index;
    logic [dtcr_pkg::ThreshW-1:0]   cfg_wdata;

    dtcr_sample_if smp ();
    dtcr_pixel_if  pix ();

    depth_to_color_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (smp),
        .pixel     (pix)
    );

    logic [dtcr_pkg::ThreshW-1:0] thr_min;
    logic [dtcr_pkg::ThreshW-1:0] thr_max;
    pixel_t             expected_pixels[$];
    pixel_t             want;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    bit                 tx_gaps_on = 1'b1;
    bit                 rx_stall_on = 1'b1;
    int                 rx_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
            $display("tb_depth_to_color_ramp: FAIL");
            $finish;
        end
    end

    // Normalizes the depth into Q16, clamps it and applies the two halves of the ramp.
    function automatic pixel_t predict_pixel(logic [dtcr_pkg::DepthW-1:0] d);
        longint num;
        longint den;
        longint frac;
        longint t;
        pixel_t p;
        if (thr_min == thr_max)
            frac = 0;
        else
        begin
            num = (longint'(d) - longint'(thr_min)) * QOne;
            den = longint'(thr_max) - longint'(thr_min);
            frac = num / den;
            if (frac < 0)
                frac = 0;
            if (frac > QOne)
                frac = QOne;
        end
        if (frac < QHalf)
        begin
            p.red = dtcr_pkg::ColorW'((255 * (QOne - 2 * frac)) / QOne);
            p.green = 8'd255;
            p.blue = 8'd0;
        end
        else
        begin
            t = 2 * frac - QOne;
            p.red = dtcr_pkg::ColorW'((51 * (QOne - t)) / QOne);
            p.green = dtcr_pkg::ColorW'((longint'(33423360) - 459 * t) / 131072);
            p.blue = dtcr_pkg::ColorW'((255 * t) / QOne);
        end
        p.level = dtcr_pkg::ColorW'((255 * frac) / QOne);
        return p;
    endfunction

    task automatic compare_channel(string name, logic [dtcr_pkg::ColorW-1:0] exp_v,
                                   logic [dtcr_pkg::ColorW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel transfer with no sample pending, %s %0d/%0d/%0d/%0d",
                         $time, "expected none actual", pix.red, pix.green, pix.blue,
                         pix.level);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_channel("red", want.red, pix.red);
                compare_channel("green", want.green, pix.green);
                compare_channel("blue", want.blue, pix.blue);
                compare_channel("level", want.level, pix.level);
            end
        end
    end

    // Output side: random stalls per transfer, plus an optional long hold-off.
    initial
    begin : pixel_ready_driver
        int stall;
        int n;
        pix.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                n = rx_hold;
                rx_hold = 0;
                repeat (n)
                begin
                    @(negedge clk);
                    pix.ready <= 1'b0;
                end
            end
            stall = rx_stall_on ? $urandom_range(0, 8) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                pix.ready <= 1'b0;
            end
            @(negedge clk);
            pix.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pix.valid && rx_hold == 0);
        end
    end

    task automatic send_depth(logic [dtcr_pkg::DepthW-1:0] d);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            smp.valid <= 1'b0;
        end
        @(negedge clk);
        smp.valid <= 1'b1;
        smp.depth <= d;
        do
            @(posedge clk);
        while (!smp.ready);
        expected_pixels = {expected_pixels, predict_pixel(d)};
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        smp.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Back-to-back calls keep the write enable high across both transfers.
    task automatic write_reg(logic [dtcr_pkg::CfgIndexW-1:0] idx,
                             logic [dtcr_pkg::ThreshW-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        unique case (idx)
            dtcr_pkg::CfgMinThreshold: thr_min = data;
            dtcr_pkg::CfgMaxThreshold: thr_max = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_thresholds(logic [dtcr_pkg::ThreshW-1:0] mn,
                                   logic [dtcr_pkg::ThreshW-1:0] mx);
        drain_pipeline();
        write_reg(dtcr_pkg::CfgMinThreshold, mn);
        write_reg(dtcr_pkg::CfgMaxThreshold, mx);
        end_writes();
    endtask

    task automatic test_reset_thresholds();
        send_depth(16'd0);
        send_depth(16'd854);
        send_depth(16'd855);
        send_depth(16'd856);
        send_depth(16'd927);
        send_depth(16'd928);
        send_depth(16'd1000);
        send_depth(16'hFFFF);
    endtask

    task automatic test_threshold_extremes();
        load_thresholds(16'h0000, 16'hFFFF);
        send_depth(16'd0);
        send_depth(16'd32767);
        send_depth(16'd32768);
        send_depth(16'hFFFF);
        // Equal thresholds force the fraction to zero.
        load_thresholds(16'd500, 16'd500);
        send_depth(16'd0);
        send_depth(16'hFFFF);
        // Inverted thresholds run the ramp backwards before clamping.
        load_thresholds(16'd60000, 16'd100);
        send_depth(16'd100);
        send_depth(16'd101);
        send_depth(16'd59999);
        send_depth(16'd60000);
        load_thresholds(16'hFFFF, 16'h0000);
        send_depth(16'd0);
        send_depth(16'hFFFF);
    endtask

    task automatic test_unknown_index();
        drain_pipeline();
        write_reg(CfgUnusedLow, 16'hFFFF);
        write_reg(CfgUnusedHigh, 16'h0000);
        write_reg(CfgUnusedLow, 16'($urandom_range(0, 65535)));
        end_writes();
        send_depth(16'd0);
        send_depth(16'd32768);
        send_depth(16'hFFFF);
    endtask

    task automatic test_output_backpressure();
        int i;
        load_thresholds(16'd1000, 16'd9000);
        tx_gaps_on = 1'b0;
        rx_stall_on = 1'b0;
        rx_hold = HoldOffCycles;
        for (i = 0; i < 40; i++)
            send_depth(16'($urandom_range(0, 10000)));
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        int i;
        load_thresholds(16'd200, 16'd4200);
        for (i = 0; i < 20; i++)
            send_depth(16'($urandom_range(0, 5000)));
        drain_pipeline();
        for (i = 0; i < 20; i++)
            send_depth(16'($urandom_range(0, 5000)));
    endtask

    task automatic test_random_ramps();
        int ph;
        int i;
        int mn;
        int mx;
        int lo;
        int hi;
        int span;
        int margin;
        int dlo;
        int dhi;
        int d;
        ramp_kind_t kind;
        for (ph = 0; ph < 10; ph++)
        begin
            kind = ramp_kind_t'($urandom_range(0, 5));
            mn = $urandom_range(0, 65535);
            span = $urandom_range(1, 400);
            unique case (kind)
                RampAny: mx = $urandom_range(0, 65535);
                RampNarrow: mx = (mn + span > 65535) ? 65535 : mn + span;
                RampInverted: mx = (mn < span) ? 0 : mn - span;
                RampFlat: mx = mn;
                RampWide:
                begin
                    mn = $urandom_range(0, 255);
                    mx = $urandom_range(65280, 65535);
                end
                default: mx = (mn + 2 > 65535) ? mn - $urandom_range(1, 2)
                                               : mn + $urandom_range(1, 2);
            endcase
            load_thresholds(16'(mn), 16'(mx));
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            lo = (mn < mx) ? mn : mx;
            hi = (mn < mx) ? mx : mn;
            margin = (hi - lo) / 4 + 8;
            dlo = (lo > margin) ? lo - margin : 0;
            dhi = (hi + margin > 65535) ? 65535 : hi + margin;
            for (i = 0; i < 100; i++)
            begin
                // Mostly depths around the ramp, some anywhere in the field.
                if ($urandom_range(0, 9) < 8)
                    d = $urandom_range(dlo, dhi);
                else if ($urandom_range(0, 3) == 0)
                    d = $urandom_range(0, 1) * 65535;
                else
                    d = $urandom_range(0, 65535);
                send_depth(16'(d));
            end
        end
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = dtcr_pkg::CfgMinThreshold;
        cfg_wdata = '0;
        smp.valid = 1'b0;
        smp.depth = '0;
        thr_min = dtcr_pkg::MinThresholdReset;
        thr_max = dtcr_pkg::MaxThresholdReset;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_thresholds();
        test_threshold_extremes();
        test_unknown_index();
        test_output_backpressure();
        test_sender_pause();
        test_random_ramps();
        drain_pipeline();

        if (mismatches == 0)
            $display("tb_depth_to_color_ramp: PASS");
        else
            $display("tb_depth_to_color_ramp: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/dtcr_pkg.sv
rtl/dtcr_if.sv
rtl/dtcr_div_stage.sv
rtl/depth_to_color_ramp.sv
tb/tb_depth_to_color_ramp.sv
